// ----- sv/clcd_pkg.sv -----
// Package for the 4-bit character LCD sequencer.
// Holds the transaction structs, request codes, phase codes and command bytes.
// No dependencies.
package clcd_pkg;

  // Request codes carried in req_type
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_CHAR   = 3'd1;
  localparam logic [2:0] REQ_CMD    = 3'd2;
  localparam logic [2:0] REQ_CURSOR = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;
  localparam logic [2:0] REQ_INIT   = 3'd5;

  // LCD command bytes
  localparam logic [7:0] CMD_RETURN_HOME = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET    = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] ROW1_BASE       = 8'h80;
  localparam logic [7:0] ROW2_BASE       = 8'hC0;

  // Delays in microseconds
  localparam int unsigned US_SHORT = 200;
  localparam int unsigned US_LONG  = 2000;
  localparam int unsigned US_START = 20000;

  // Tick count widths: up to 255 ticks per microsecond
  localparam int unsigned SHORT_W = 16;
  localparam int unsigned LONG_W  = 19;
  localparam int unsigned CNT_W   = 23;

  // Index of the last command in the init sequence
  localparam logic [2:0] INIT_LAST = 3'd4;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_START  = 7'b0000010,
    PH_EHI    = 7'b0000100,
    PH_HOLDHI = 7'b0001000,
    PH_ELO    = 7'b0010000,
    PH_HOLDLO = 7'b0100000,
    PH_FINAL  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic [1:0] cursor_row;
    logic [5:0] cursor_col;
  } req_t;

  typedef struct packed {
    logic [3:0] bus_nibble;
    logic       reg_select;
    logic       enable_pin;
    logic       accepted;
    logic       busy_res;
  } res_t;

  // Init sequence command table
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CMD_RETURN_HOME;
      3'd1:    c = CMD_FUNC_SET;
      3'd2:    c = CMD_DISPLAY_ON;
      3'd3:    c = CMD_ENTRY_MODE;
      3'd4:    c = CMD_CLEAR;
      default: c = CMD_CLEAR;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/char_lcd_4bit_sequencer_core.sv -----
// Top level of the 4-bit character LCD sequencer.
// Depends on clcd_pkg for transaction structs, codes and the init command table.
//
// One transaction is taken per clock: a request or a tick updates the phase
// state and the counter in the accepting cycle and its result sits in the
// output register from the next cycle; the throughput is one item per cycle
// whenever the output side keeps taking results. in_ready follows the output
// register alone (empty, or being taken). Time inside a sequence moves only
// on tick transactions; the configuration register sets how many ticks make
// one microsecond (zero acts as one), and the delay tick counts are formed
// once at each configuration write.
module char_lcd_4bit_sequencer_core
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  // Delay lengths in ticks
  logic [7:0]         t_enable;
  logic [SHORT_W-1:0] t_short;
  logic [LONG_W-1:0]  t_long;
  logic [CNT_W-1:0]   t_start;
  logic [7:0]         tpm_eff;

  // Sequencer state
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] count, count_next;
  logic [3:0]       bus, bus_next;
  logic             rs, rs_next;
  logic [7:0]       cur_byte, cur_byte_next;
  logic [2:0]       init_idx, init_idx_next;
  logic             in_init, in_init_next;
  logic             final_wait, final_wait_next;
  logic             acc;

  logic             in_fire;
  logic [CNT_W-1:0] cnt_dec;
  logic [7:0]       pos;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign tpm_eff   = (cfg_data == 8'd0) ? 8'd1 : cfg_data;

  // Form delay tick counts at each configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      t_enable <= 8'd1;
      t_short  <= SHORT_W'(US_SHORT);
      t_long   <= LONG_W'(US_LONG);
      t_start  <= CNT_W'(US_START);
    end else if (cfg_valid && cfg_ready) begin
      t_enable <= tpm_eff;
      t_short  <= SHORT_W'(US_SHORT) * SHORT_W'(tpm_eff);
      t_long   <= LONG_W'(US_LONG) * LONG_W'(tpm_eff);
      t_start  <= CNT_W'(US_START) * CNT_W'(tpm_eff);
    end
  end

  // Cursor address from row (1 or 2) and column; any other row gives the first row's base
  always_comb begin
    case (in_data.cursor_row)
      2'd1:    pos = ROW1_BASE + {2'b00, in_data.cursor_col};
      2'd2:    pos = ROW2_BASE + {2'b00, in_data.cursor_col};
      default: pos = ROW1_BASE;
    endcase
  end

  assign cnt_dec = (count != '0) ? count - CNT_W'(1) : '0;

  // Next state for one transaction
  always_comb begin
    phase_next      = phase;
    count_next      = count;
    bus_next        = bus;
    rs_next         = rs;
    cur_byte_next   = cur_byte;
    init_idx_next   = init_idx;
    in_init_next    = in_init;
    final_wait_next = final_wait;
    acc             = 1'b0;

    if (in_data.req_type == REQ_TICK) begin
      acc = 1'b1;
      if (phase != PH_IDLE) begin
        count_next = cnt_dec;
        if (cnt_dec == '0) begin
          // Advance to the next phase
          case (phase)
            PH_START: begin
              init_idx_next = 3'd0;
              cur_byte_next = init_cmd(3'd0);
              rs_next       = 1'b0;
              bus_next      = 4'(init_cmd(3'd0) >> 4);
              phase_next    = PH_EHI;
              count_next    = CNT_W'(t_enable);
            end
            PH_EHI: begin
              phase_next = PH_HOLDHI;
              count_next = CNT_W'(t_short);
            end
            PH_HOLDHI: begin
              bus_next   = cur_byte[3:0];
              phase_next = PH_ELO;
              count_next = CNT_W'(t_enable);
            end
            PH_ELO: begin
              phase_next = PH_HOLDLO;
              count_next = CNT_W'(t_long);
            end
            PH_HOLDLO: begin
              if (in_init && init_idx < INIT_LAST) begin
                init_idx_next = init_idx + 3'd1;
                cur_byte_next = init_cmd(init_idx + 3'd1);
                rs_next       = 1'b0;
                bus_next      = 4'(init_cmd(init_idx + 3'd1) >> 4);
                phase_next    = PH_EHI;
                count_next    = CNT_W'(t_enable);
              end else if (final_wait) begin
                phase_next = PH_FINAL;
                count_next = CNT_W'(t_long);
              end else begin
                phase_next = PH_IDLE;
                count_next = '0;
              end
            end
            default: begin
              phase_next      = PH_IDLE;
              count_next      = '0;
              in_init_next    = 1'b0;
              final_wait_next = 1'b0;
            end
          endcase
        end
      end
    end else if (in_data.req_type <= REQ_INIT && phase == PH_IDLE) begin
      acc             = 1'b1;
      in_init_next    = 1'b0;
      final_wait_next = 1'b0;
      phase_next      = PH_EHI;
      count_next      = CNT_W'(t_enable);
      rs_next         = 1'b0;
      case (in_data.req_type)
        REQ_CHAR: begin
          cur_byte_next = in_data.data_byte;
          rs_next       = 1'b1;
        end
        REQ_CMD: begin
          cur_byte_next = in_data.data_byte;
        end
        REQ_CURSOR: begin
          cur_byte_next = pos;
        end
        REQ_CLEAR: begin
          cur_byte_next   = CMD_CLEAR;
          final_wait_next = 1'b1;
        end
        default: begin
          // Init: start wait, bus and register select keep their levels
          in_init_next    = 1'b1;
          final_wait_next = 1'b1;
          init_idx_next   = 3'd0;
          phase_next      = PH_START;
          count_next      = t_start;
          rs_next         = rs;
        end
      endcase
      if (in_data.req_type != REQ_INIT) begin
        bus_next = cur_byte_next[7:4];
      end
    end
  end

  // Update state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      count      <= '0;
      bus        <= 4'd0;
      rs         <= 1'b0;
      cur_byte   <= 8'd0;
      init_idx   <= 3'd0;
      in_init    <= 1'b0;
      final_wait <= 1'b0;
    end else if (in_fire) begin
      phase      <= phase_next;
      count      <= count_next;
      bus        <= bus_next;
      rs         <= rs_next;
      cur_byte   <= cur_byte_next;
      init_idx   <= init_idx_next;
      in_init    <= in_init_next;
      final_wait <= final_wait_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.bus_nibble <= bus_next;
      out_data.reg_select <= rs_next;
      out_data.enable_pin <= (phase_next == PH_EHI) || (phase_next == PH_ELO);
      out_data.accepted   <= acc;
      out_data.busy_res   <= (phase_next != PH_IDLE);
    end
  end

`ifndef SYNTH
  // A running phase always has time left, idle has none
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (count != '0))
    else $error("running phase with zero count");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (count == '0))
    else $error("idle phase with nonzero count");

  a_init_idx: assert property (@(posedge clk) disable iff (rst)
    init_idx <= INIT_LAST)
    else $error("init index past last command");

  // A tick is never refused
  a_tick_taken: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.req_type == REQ_TICK) |=> out_data.accepted)
    else $error("tick transaction refused");

  // Enable strobe only while a sequence runs
  a_enable_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.enable_pin) |-> out_data.busy_res)
    else $error("enable high while not busy");
`endif

endmodule
